// ----- design/pfys_pkg.sv -----
// Shared widths, table entry type and register index codes for the sampler.
package pfys_pkg;

   // Width of population size, sample count, step index and emitted index
   localparam int STEP_W  = 13;
   // Width of a stored table value
   localparam int ENTRY_W = 12;
   // Width of the run tag kept with each table entry
   localparam int TAG_W   = 8;
   // Width of the base value register
   localparam int BASE_W  = 32;
   // Width of the emitted sample value
   localparam int SAMPLE_W = BASE_W + 1;
   // Width of the configuration index
   localparam int CSR_IDX_W = 2;

   // Tag zero marks entries cleared by a sweep; live runs use the others
   localparam logic [TAG_W-1:0] TAG_SWEPT = '0;
   localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);
   localparam logic [TAG_W-1:0] TAG_LAST  = '1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POPULATION_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_VALUE      = 2'd2;

   // One table entry: the run tag it was written in and the stored value
   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [ENTRY_W-1:0] value;
   } table_entry_type;

endpackage

// ----- design/pfys_divider.sv -----
// Restoring serial divider that returns the remainder, one quotient bit a cycle.
module pfys_divider
   import pfys_pkg::*;
#(
   parameter int RANDOM_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [RANDOM_WIDTH-1:0] dividend,
   input  logic [STEP_W-1:0]       divisor,
   output logic                    busy,
   output logic [STEP_W-1:0]       remainder
);

   localparam int CNT_W = $clog2(RANDOM_WIDTH + 1);

   logic [RANDOM_WIDTH-1:0] quot_ff, quot_in;
   logic [STEP_W-1:0]       rem_ff, rem_in;
   logic [STEP_W-1:0]       div_ff, div_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [STEP_W:0]         trial;

   // One shift-and-subtract step; the partial remainder stays below the divisor
   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      count_in = count_ff;
      trial    = {rem_ff, quot_ff[RANDOM_WIDTH-1]};
      if (start) begin
         quot_in  = dividend;
         rem_in   = '0;
         div_in   = divisor;
         count_in = CNT_W'(RANDOM_WIDTH);
      end else if (count_ff != '0) begin
         quot_in  = {quot_ff[RANDOM_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = STEP_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[STEP_W-1:0];
         end
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign busy      = (count_ff != '0);
   assign remainder = rem_ff;

endmodule

// ----- design/pfys_table.sv -----
// Index table memory with registered read and run-tag check on the read value.
module pfys_table
   import pfys_pkg::*;
#(
   parameter int DEPTH = 4096
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  table_entry_type            wr_entry,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   input  logic [TAG_W-1:0]           epoch,
   output logic [STEP_W-1:0]          rd_value
);

   localparam int ADDR_W = $clog2(DEPTH);

   table_entry_type   mem_ff [DEPTH];
   table_entry_type   rd_entry_ff;
   logic [ADDR_W-1:0] rd_addr_ff;

   // Synchronous write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= mem_ff[rd_addr];
      rd_addr_ff  <= rd_addr;
   end

   // An entry not written in the current run reads as its own index
   assign rd_value = (rd_entry_ff.tag == epoch) ? STEP_W'(rd_entry_ff.value)
                                                : STEP_W'(rd_addr_ff);

endmodule

// ----- design/partial_fisher_yates_sampler.sv -----
// Partial Fisher-Yates sampler: top level with sequencer, registers and result stage.
// Each accepted item carries one random word and returns one sample drawn without
// replacement from base_value .. base_value + population_size - 1. For each item the
// serial remainder unit retires one bit of the random word per cycle, then the table
// port does two reads and two writes for the swap, then the result is loaded. The
// written map is kept as a run tag stored with every table entry; ending a run bumps
// the tag. After reset, and after every 255th run when the tag wraps, a clearing pass
// over all TABLE_DEPTH entries sweeps the table while no item is accepted.
// A result waits in an output register; the next item is taken once it has gone out
// of the sequencer.
module partial_fisher_yates_sampler
   import pfys_pkg::*;
#(
   parameter int TABLE_DEPTH  = 4096,
   parameter int RANDOM_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   // item input
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [RANDOM_WIDTH-1:0]    req_random_word,
   // result output
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample_value,
   output logic                       rsp_last_sample,
   output logic                       rsp_size_error,
   // configuration writes
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [BASE_W-1:0]          csr_data
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CAP    = (TABLE_DEPTH < (2**STEP_W - 1)) ? TABLE_DEPTH : (2**STEP_W - 1);
   localparam logic [STEP_W-1:0] CAP_N     = STEP_W'(CAP);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

   typedef enum logic [7:0] {
      S_SWEEP = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_DIV   = 8'b0000_0100,
      S_RDK   = 8'b0000_1000,
      S_RDJ   = 8'b0001_0000,
      S_WRJ   = 8'b0010_0000,
      S_WRK   = 8'b0100_0000,
      S_RESP  = 8'b1000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   pop_ff, pop_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [STEP_W-1:0]   k_ff, k_in;
   logic [STEP_W-1:0]   j_ff, j_in;
   logic [STEP_W-1:0]   vk_ff, vk_in;
   logic [STEP_W-1:0]   vj_ff, vj_in;
   logic                last_ff, last_in;
   logic                err_ff, err_in;
   logic [TAG_W-1:0]    epoch_ff, epoch_in;
   logic [ADDR_W-1:0]   sweep_addr_ff, sweep_addr_in;
   logic                sweep_to_div_ff, sweep_to_div_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_err_ff, rsp_err_in;

   logic                accept;
   logic                rsp_load;
   logic [STEP_W-1:0]   n_eff;
   logic [STEP_W-1:0]   cnt_eff;
   logic                size_err;
   logic                restart;
   logic [STEP_W-1:0]   k_sel;
   logic                last_sel;
   logic                div_start;
   logic                div_busy;
   logic [STEP_W-1:0]   div_rem;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   table_entry_type     wr_entry;
   logic [ADDR_W-1:0]   rd_addr;
   logic [STEP_W-1:0]   rd_value;
   logic [SAMPLE_W-1:0] sample_sum;

   // Handshake
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_load  = (state_ff == S_RESP) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   // Effective run bounds for the item being accepted
   assign n_eff    = (pop_ff > CAP_N) ? CAP_N : pop_ff;
   assign cnt_eff  = (cnt_ff == '0) ? STEP_W'(1) : cnt_ff;
   assign size_err = (cnt_eff > n_eff);
   assign restart  = (step_ff >= cnt_eff);
   assign k_sel    = restart ? '0 : step_ff;
   assign last_sel = (({1'b0, k_sel} + 1'b1) == {1'b0, cnt_eff});
   assign div_start = accept && !size_err;

   // Sample is base plus the chosen index, sign-extended to the output width
   assign sample_sum = {base_ff[BASE_W-1], base_ff} + SAMPLE_W'(vj_ff);

   pfys_divider #(
      .RANDOM_WIDTH(RANDOM_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_random_word),
      .divisor  (n_eff - k_sel),
      .busy     (div_busy),
      .remainder(div_rem)
   );

   // Table port selection
   always_comb begin
      wr_en          = 1'b0;
      wr_addr        = ADDR_W'(j_ff);
      wr_entry.tag   = epoch_ff;
      wr_entry.value = vk_ff[ENTRY_W-1:0];
      rd_addr        = ADDR_W'(k_ff);
      unique case (state_ff)
         S_SWEEP: begin
            wr_en          = 1'b1;
            wr_addr        = sweep_addr_ff;
            wr_entry.tag   = TAG_SWEPT;
            wr_entry.value = '0;
         end
         S_RDJ: begin
            rd_addr = ADDR_W'(j_ff);
         end
         S_WRJ: begin
            wr_en = 1'b1;
         end
         S_WRK: begin
            wr_en          = 1'b1;
            wr_addr        = ADDR_W'(k_ff);
            wr_entry.value = vj_ff[ENTRY_W-1:0];
         end
         default: begin
         end
      endcase
   end

   pfys_table #(
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_entry(wr_entry),
      .rd_addr (rd_addr),
      .epoch   (epoch_ff),
      .rd_value(rd_value)
   );

   // Configuration register writes
   always_comb begin
      pop_in  = pop_ff;
      cnt_in  = cnt_ff;
      base_in = base_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_POPULATION_SIZE: pop_in  = csr_data[STEP_W-1:0];
            CSR_SAMPLE_COUNT:    cnt_in  = csr_data[STEP_W-1:0];
            CSR_BASE_VALUE:      base_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      k_in            = k_ff;
      j_in            = j_ff;
      vk_in           = vk_ff;
      vj_in           = vj_ff;
      last_in         = last_ff;
      err_in          = err_ff;
      epoch_in        = epoch_ff;
      sweep_addr_in   = sweep_addr_ff;
      sweep_to_div_in = sweep_to_div_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_sample_in   = rsp_sample_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_err_in      = rsp_err_ff;
      unique case (state_ff)
         S_SWEEP: begin
            if (sweep_addr_ff == LAST_ADDR) begin
               sweep_addr_in = '0;
               state_in      = sweep_to_div_ff ? S_DIV : S_IDLE;
            end else begin
               sweep_addr_in = sweep_addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (accept) begin
               err_in  = size_err;
               k_in    = k_sel;
               last_in = last_sel;
               if (size_err) begin
                  state_in = S_RESP;
               end else if (restart && (epoch_ff == TAG_LAST)) begin
                  // counter ran past the run: start a new one, tag wraps
                  epoch_in        = TAG_FIRST;
                  sweep_to_div_in = 1'b1;
                  state_in        = S_SWEEP;
               end else begin
                  if (restart) begin
                     epoch_in = epoch_ff + 1'b1;
                  end
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (!div_busy) begin
               j_in     = k_ff + div_rem;
               state_in = S_RDK;
            end
         end
         S_RDK: begin
            state_in = S_RDJ;
         end
         S_RDJ: begin
            vk_in    = rd_value;
            state_in = S_WRJ;
         end
         S_WRJ: begin
            vj_in    = rd_value;
            state_in = S_WRK;
         end
         S_WRK: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = err_ff ? '0 : sample_sum;
               rsp_last_in   = !err_ff && last_ff;
               rsp_err_in    = err_ff;
               state_in      = S_IDLE;
               if (err_ff || last_ff) begin
                  // run ends: forget the written entries
                  step_in = '0;
                  if (epoch_ff == TAG_LAST) begin
                     epoch_in        = TAG_FIRST;
                     sweep_to_div_in = 1'b0;
                     state_in        = S_SWEEP;
                  end else begin
                     epoch_in = epoch_ff + 1'b1;
                  end
               end else begin
                  step_in = k_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_SWEEP;
         pop_ff          <= STEP_W'(4096);
         cnt_ff          <= STEP_W'(1);
         base_ff         <= '0;
         step_ff         <= '0;
         epoch_ff        <= TAG_FIRST;
         sweep_addr_ff   <= '0;
         sweep_to_div_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pop_ff          <= pop_in;
         cnt_ff          <= cnt_in;
         base_ff         <= base_in;
         step_ff         <= step_in;
         epoch_ff        <= epoch_in;
         sweep_addr_ff   <= sweep_addr_in;
         sweep_to_div_ff <= sweep_to_div_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      k_ff          <= k_in;
      j_ff          <= j_in;
      vk_ff         <= vk_in;
      vj_ff         <= vj_in;
      last_ff       <= last_in;
      err_ff        <= err_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = $signed(rsp_sample_ff);
   assign rsp_last_sample  = rsp_last_ff;
   assign rsp_size_error   = rsp_err_ff;

   // Table reads start only once the remainder is complete
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RDK) |-> !div_busy)
      else $error("table read started while remainder unit busy");

   // The live tag never equals the tag left by a sweep
   a_epoch_live: assert property (@(posedge clock) disable iff (reset)
      epoch_ff != TAG_SWEPT)
      else $error("run tag collides with swept entries");

   // An error result carries no sample and no end of run
   a_err_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_size_error) |-> (rsp_sample_value == '0 && !rsp_last_sample))
      else $error("size error result carries a sample");

   // After the last sample of a run the step counter restarts
   a_run_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (last_ff || err_ff)) |=> (step_ff == '0))
      else $error("step counter not restarted at end of run");

   // The swap indexes stay inside the table
   a_swap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRJ) |-> (j_ff >= k_ff && j_ff < n_eff))
      else $error("swap index outside the remaining population");

endmodule
